[rtl/pbpd_pkg.sv]
// Shared types and constants for the PCI BAR probe decoder.
package pbpd_pkg;

  localparam int SlotW  = 3;
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_IO    = 2'd1;
  localparam logic [1:0] KIND_MEM32 = 2'd2;
  localparam logic [1:0] KIND_MEM64 = 2'd3;

  // Memory type field of a memory BAR, bits 2:1
  localparam logic [1:0] MTYPE_64 = 2'b10;

  typedef struct packed {
    logic [31:0] bar_value;
    logic [31:0] size_readback;
    logic        bridge_header;
  } in_item_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [1:0]       bar_kind;
    logic [63:0]      base_address;
    logic [63:0]      region_size;
    logic             prefetchable;
    logic             last_slot;
  } out_item_t;

  // NONE: one empty descriptor. DECODE: one decoded descriptor.
  // PAIR: 64-bit descriptor for the previous slot, then empty for this slot.
  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_DECODE,
    JOB_PAIR
  } job_mode_t;

  typedef struct packed {
    job_mode_t        mode;
    logic [SlotW-1:0] slot;
    logic             last;
    logic [31:0]      lo;
    logic [31:0]      szlo;
    logic [31:0]      hi;
    logic [31:0]      szhi;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/pbpd_front.sv]
// Front end: accepts slot items, tracks slot position and held 64-bit low halves.
module pbpd_front
  import pbpd_pkg::*;
#(
  parameter int MAX_SLOTS = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_item,
  input  q_status_t q_status,
  output logic      push,
  output job_t      push_job
);

  localparam logic [SlotW:0] MaxSlotsW = (SlotW+1)'(MAX_SLOTS);

  logic [SlotW-1:0] slot_r, slot_nxt;
  logic             pending_r, pending_nxt;
  logic [31:0]      held_lo_r, held_lo_nxt;
  logic [31:0]      held_sz_r, held_sz_nxt;

  logic             accept;
  logic [SlotW:0]   nslots;
  logic             last;
  logic             empty_bar;
  logic             is_mem64;
  logic             hold;

  assign accept    = in_valid && !q_status.full;
  assign nslots    = in_item.bridge_header ? (SlotW+1)'(2) : MaxSlotsW;
  assign last      = ({1'b0, slot_r} + (SlotW+1)'(1)) >= nslots;
  assign empty_bar = (in_item.bar_value == '0) || (in_item.size_readback == '0) ||
                     (in_item.size_readback == '1);
  assign is_mem64  = !in_item.bar_value[0] && (in_item.bar_value[2:1] == MTYPE_64);
  assign hold      = !pending_r && !empty_bar && is_mem64 && !last;

  always_comb begin
    push_job.slot = slot_r;
    push_job.last = last;
    push_job.lo   = in_item.bar_value;
    push_job.szlo = in_item.size_readback;
    push_job.hi   = '0;
    push_job.szhi = '0;
    if (pending_r) begin
      push_job.mode = JOB_PAIR;
      push_job.lo   = held_lo_r;
      push_job.szlo = held_sz_r;
      push_job.hi   = in_item.bar_value;
      push_job.szhi = in_item.size_readback;
    end else if (empty_bar) begin
      push_job.mode = JOB_NONE;
    end else begin
      push_job.mode = JOB_DECODE;
    end
  end

  assign push = accept && !hold;

  always_comb begin
    slot_nxt    = slot_r;
    pending_nxt = pending_r;
    held_lo_nxt = held_lo_r;
    held_sz_nxt = held_sz_r;
    if (accept) begin
      slot_nxt = last ? '0 : slot_r + SlotW'(1);
      if (pending_r) begin
        pending_nxt = 1'b0;
      end else if (hold) begin
        pending_nxt = 1'b1;
        held_lo_nxt = in_item.bar_value;
        held_sz_nxt = in_item.size_readback;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      pending_r <= 1'b0;
    end else begin
      slot_r    <= slot_nxt;
      pending_r <= pending_nxt;
    end
  end

  // Only read while pending is set, so no reset needed
  always_ff @(posedge clk) begin
    held_lo_r <= held_lo_nxt;
    held_sz_r <= held_sz_nxt;
  end

endmodule

[rtl/pbpd_queue.sv]
// Short job queue between front end and back end.
module pbpd_queue
  import pbpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t status
);

  job_t             entry_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] count_r, count_nxt;

  assign status.full  = (count_r == QCntW'(QDepth));
  assign status.empty = (count_r == '0);
  assign head         = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPtrW'(1) : rd_ptr_r;
    count_nxt  = count_r + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[rtl/pbpd_back.sv]
// Back end: decodes queued jobs into descriptors and drives the result register.
module pbpd_back
  import pbpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      phase_r, phase_nxt;

  logic      load;
  logic      take;
  out_item_t dec;
  out_item_t none_desc;
  logic [31:0] io_size;
  logic [31:0] m32_size;
  logic [63:0] m64_mask;

  assign load = !out_valid_r || !out_stall;
  assign take = load && !q_status.empty;
  assign pop  = take && ((head.mode != JOB_PAIR) || phase_r);

  assign io_size  = ~(head.szlo & ~32'h3) + 32'd1;
  assign m32_size = ~(head.szlo & ~32'hF) + 32'd1;
  assign m64_mask = {head.szhi, head.szlo & ~32'hF};

  always_comb begin
    dec.slot         = (head.mode == JOB_PAIR) ? head.slot - SlotW'(1) : head.slot;
    dec.last_slot    = (head.mode == JOB_PAIR) ? 1'b0 : head.last;
    dec.prefetchable = head.lo[3];
    if (head.lo[0]) begin
      dec.bar_kind     = KIND_IO;
      dec.base_address = {32'd0, head.lo & ~32'h3};
      dec.region_size  = {48'd0, io_size[15:0]};
      dec.prefetchable = 1'b0;
    end else if (head.lo[2:1] == MTYPE_64) begin
      dec.bar_kind     = KIND_MEM64;
      dec.base_address = {head.hi, head.lo & ~32'hF};
      dec.region_size  = ~m64_mask + 64'd1;
    end else begin
      dec.bar_kind     = KIND_MEM32;
      dec.base_address = {32'd0, head.lo & ~32'hF};
      dec.region_size  = {32'd0, m32_size};
    end
  end

  always_comb begin
    none_desc.slot         = head.slot;
    none_desc.bar_kind     = KIND_NONE;
    none_desc.base_address = '0;
    none_desc.region_size  = '0;
    none_desc.prefetchable = 1'b0;
    none_desc.last_slot    = head.last;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    phase_nxt     = phase_r;
    if (load) begin
      out_valid_nxt = !q_status.empty;
    end
    if (take) begin
      case (head.mode)
        JOB_NONE: begin
          out_item_nxt = none_desc;
        end
        JOB_DECODE: begin
          out_item_nxt = dec;
        end
        JOB_PAIR: begin
          out_item_nxt = phase_r ? none_desc : dec;
          phase_nxt    = !phase_r;
        end
        default: begin
          out_item_nxt = none_desc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/pci_bar_probe_decoder.sv]
// An accepted item's job is written into the job queue, and its first descriptor from there into the output register.
// Throughput: one item per cycle while in_stall is low; a 64-bit BAR's upper-half item yields two
//   descriptors, taken by the back end one after the other, and a held low half yields none.
// in_stall rises only when the 4-entry job queue is full.
// Reset (rst_n low, synchronous) empties the queue and output register and
//   returns the slot counter and 64-bit hold to zero.
module pci_bar_probe_decoder
  import pbpd_pkg::*;
#(
  parameter int MAX_SLOTS = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // Front end classifies each slot item into a job; back end turns jobs into
  // descriptors. The queue lets either side stall without the other.
  logic      push;
  job_t      push_job;
  logic      pop;
  job_t      head;
  q_status_t q_status;

  assign in_stall = q_status.full;

  pbpd_front #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  pbpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Back end: one descriptor per cycle into the output register while jobs are queued and out_stall is low
  pbpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[rtl/pbpd_checker.sv]
// Port-level checks for the PCI BAR probe decoder, bound to the top level.
module pbpd_checker
  import pbpd_pkg::*;
#(
  parameter int MAX_SLOTS = 6
) (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.bar_kind == KIND_NONE) |->
      (out_item.base_address == '0) && (out_item.region_size == '0) &&
      !out_item.prefetchable)
    else $error("empty descriptor carries data");

  a_io_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.bar_kind == KIND_IO) |->
      (out_item.region_size[63:16] == '0) && !out_item.prefetchable)
    else $error("I/O descriptor not masked");

  a_mem64_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_item.bar_kind == KIND_MEM64) && !out_item.last_slot |=>
      out_valid && (out_item.slot == $past(out_item.slot) + SlotW'(1)))
    else $error("64-bit descriptor not followed by its upper slot");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.slot < SlotW'(MAX_SLOTS))
    else $error("slot index out of range");

endmodule

bind pci_bar_probe_decoder pbpd_checker #(
  .MAX_SLOTS(MAX_SLOTS)
) u_pbpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

[tb/sv/tb.sv]
// Testbench for pci_bar_probe_decoder: slot streams in, descriptors checked in order.
`timescale 1ns / 100ps

module tb;
  import pbpd_pkg::*;

  localparam int          MAX_SLOTS     = 6;
  localparam int          IDLE_PCT      = 37;
  localparam int          HOLD_CYCLES   = 200;  // long receiver hold-off
  localparam int          HOLD_AT_ITEM  = 300;
  localparam int          QUIET_FROM    = 600;  // no idling on either side
  localparam int          QUIET_TO      = 800;
  localparam int          RANDOM_ITEMS  = 1150;
  localparam int          DRAIN_CYCLES  = 8;    // extra wait after the last expected descriptor
  localparam logic [31:0] IO_FLAGS      = 32'h3;
  localparam logic [31:0] MEM_FLAGS     = 32'hF;
  localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int in_count = 0;
  int dev_count = 0;
  bit hold_done = 1'b0;

  pci_bar_probe_decoder #(
    .MAX_SLOTS(MAX_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Descriptor predictor plus the queue of descriptors still owed by the block.
  class bar_scoreboard;
    logic [2:0]  slot_cnt;
    bit          upper_pending;
    logic [31:0] held_lo;
    logic [31:0] held_sz;
    out_item_t   desc_q[$];
    int          errors;
    int          checked;
    int          kind_seen[4];

    function new();
      slot_cnt      = '0;
      upper_pending = 1'b0;
      held_lo       = '0;
      held_sz       = '0;
      errors        = 0;
      checked       = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function out_item_t empty_desc(logic [2:0] slot, bit last);
      out_item_t d;
      d           = '0;
      d.slot      = slot;
      d.bar_kind  = KIND_NONE;
      d.last_slot = last;
      return d;
    endfunction

    // Full BAR decode from low and high halves (high is zero for 32-bit or final slot).
    function out_item_t decode_bar(logic [2:0] slot, bit last, logic [31:0] lo,
                                   logic [31:0] szlo, logic [31:0] hi, logic [31:0] szhi);
      out_item_t   d;
      logic [31:0] sz32;
      logic [63:0] mask;
      d           = '0;
      d.slot      = slot;
      d.last_slot = last;
      if (lo[0]) begin
        d.bar_kind     = KIND_IO;
        d.base_address = {32'd0, lo & ~IO_FLAGS};
        sz32           = ~(szlo & ~IO_FLAGS) + 32'd1;
        d.region_size  = {48'd0, sz32[15:0]};
      end else begin
        d.prefetchable = lo[3];
        if (lo[2:1] == MTYPE_64) begin
          d.bar_kind     = KIND_MEM64;
          d.base_address = {hi, lo & ~MEM_FLAGS};
          mask           = {szhi, szlo & ~MEM_FLAGS};
          d.region_size  = ~mask + 64'd1;
        end else begin
          d.bar_kind     = KIND_MEM32;
          d.base_address = {32'd0, lo & ~MEM_FLAGS};
          sz32           = ~(szlo & ~MEM_FLAGS) + 32'd1;
          d.region_size  = {32'd0, sz32};
        end
      end
      return d;
    endfunction

    function void note_input(in_item_t it);
      int         nslots;
      logic [2:0] slot;
      bit         last;
      nslots = it.bridge_header ? 2 : MAX_SLOTS;
      slot   = slot_cnt;
      last   = (int'(slot) + 1 >= nslots);
      if (upper_pending) begin
        // this item is the upper half: 64-bit descriptor for the previous slot, then none
        desc_q.push_back(decode_bar(slot - 3'd1, 1'b0, held_lo, held_sz,
                                    it.bar_value, it.size_readback));
        desc_q.push_back(empty_desc(slot, last));
        upper_pending = 1'b0;
        held_lo       = '0;
        held_sz       = '0;
      end else if (it.bar_value == '0 || it.size_readback == '0 ||
                   it.size_readback == ALL_ONES) begin
        desc_q.push_back(empty_desc(slot, last));
      end else if (!it.bar_value[0] && it.bar_value[2:1] == MTYPE_64 && !last) begin
        upper_pending = 1'b1;
        held_lo       = it.bar_value;
        held_sz       = it.size_readback;
      end else begin
        desc_q.push_back(decode_bar(slot, last, it.bar_value, it.size_readback, '0, '0));
      end
      slot_cnt = last ? 3'd0 : slot + 3'd1;
    endfunction

    function void cmp_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (desc_q.size() == 0) begin
        $error("descriptor with none expected: slot %0d kind %0d", got.slot, got.bar_kind);
        errors++;
        return;
      end
      e = desc_q.pop_front();
      checked++;
      kind_seen[e.bar_kind]++;
      cmp_field("slot", e.slot, got.slot);
      cmp_field("bar_kind", e.bar_kind, got.bar_kind);
      cmp_field("base_address", e.base_address, got.base_address);
      cmp_field("region_size", e.region_size, got.region_size);
      cmp_field("prefetchable", e.prefetchable, got.prefetchable);
      cmp_field("last_slot", e.last_slot, got.last_slot);
    endfunction
  endclass

  bar_scoreboard sb;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit quiet_phase();
    return in_count >= QUIET_FROM && in_count < QUIET_TO;
  endfunction

  // Offer one slot item; called and returns at a falling edge. in_valid is only
  // lowered on an idle cycle, so it never sees two updates in one step.
  task automatic send_bar(logic [31:0] bar, logic [31:0] rb, bit bridge);
    in_item_t it;
    it.bar_value     = bar;
    it.size_readback = rb;
    it.bridge_header = bridge;
    while (!quiet_phase() && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    in_count++;
    @(negedge clk);
  endtask

  // One device worth of plausible BARs; pads out any partial device first.
  task automatic send_device();
    bit          br;
    bit          brk;
    bit          pf;
    int          n;
    int          s;
    int          pick;
    int          k;
    int          tsel;
    logic [1:0]  mtype;
    logic [63:0] m;
    logic [31:0] flags;
    logic [31:0] bar;
    logic [31:0] rb;
    // noise until the block is back at slot 0 with no half-held BAR
    while (sb.slot_cnt != 3'd0 || sb.upper_pending)
      send_bar($urandom, $urandom, 1'($urandom_range(1)));
    br = ($urandom_range(3) == 0);
    n  = br ? 2 : MAX_SLOTS;
    s  = 0;
    while (s < n) begin
      brk  = ($urandom_range(24) == 0);  // occasional header kind flip mid-device
      pick = $urandom_range(9);
      pf   = 1'($urandom_range(1));
      if (pick < 2) begin
        case ($urandom_range(2))
          0:       send_bar('0, $urandom, br ^ brk);
          1:       send_bar($urandom, '0, br ^ brk);
          default: send_bar($urandom, ALL_ONES, br ^ brk);
        endcase
        s++;
      end else if (pick < 4) begin
        k  = $urandom_range(2, 16);
        m  = ~((64'd1 << k) - 64'd1);
        rb = (m[31:0] & ~IO_FLAGS) | 32'd1 | (32'($urandom_range(1)) << 1);
        if ($urandom_range(1)) rb[31:16] = '0;
        bar = ($urandom & m[31:0] & ~IO_FLAGS) | 32'd1 | (32'($urandom_range(1)) << 1);
        send_bar(bar, rb, br ^ brk);
        s++;
      end else if (pick < 6) begin
        k     = $urandom_range(4, 31);
        m     = ~((64'd1 << k) - 64'd1);
        tsel  = $urandom_range(2);
        mtype = (tsel == 2) ? 2'b11 : 2'(tsel);
        flags = {28'd0, pf, mtype, 1'b0};
        rb    = (m[31:0] & ~MEM_FLAGS) | flags;
        bar   = ($urandom & m[31:0] & ~MEM_FLAGS) | flags;
        send_bar(bar, rb, br ^ brk);
        s++;
      end else begin
        k     = ($urandom_range(7) == 0) ? $urandom_range(33, 63) : $urandom_range(4, 32);
        m     = ~((64'd1 << k) - 64'd1);
        flags = {28'd0, pf, MTYPE_64, 1'b0};
        rb    = (m[31:0] & ~MEM_FLAGS) | flags;
        bar   = ($urandom & m[31:0] & ~MEM_FLAGS) | flags;
        send_bar(bar, rb, br ^ brk);
        s++;
        if (s < n) begin
          if ($urandom_range(15) == 0) send_bar($urandom, $urandom, br);
          else send_bar($urandom & m[63:32], m[63:32], br);
          s++;
        end
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off so the job queue fills and
  // in_stall backs up the sender.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && in_count >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= quiet_phase() ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Normal header, six slots: empty, I/O, prefetchable mem32, 64-bit pair,
    // and a 64-bit BAR in the final slot (decoded with zero upper half).
    send_bar(32'h0000_0000, 32'hFFFF_F000, 1'b0);
    send_bar(32'h0000_C001, 32'hFFFF_FFE1, 1'b0);
    send_bar(32'hFEB0_0008, 32'hFFF0_0008, 1'b0);
    send_bar(32'hE000_000C, 32'hF000_000C, 1'b0);
    send_bar(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);  // upper half, all-ones readback
    send_bar(32'hD000_0004, 32'hFFFF_0004, 1'b0);
    // Bridge: 64-bit region of 4 GiB and up; upper half with zero readback
    send_bar(32'h8000_0004, 32'h0000_0004, 1'b1);
    send_bar(32'h0000_0002, 32'h0000_0000, 1'b1);
    // Bridge: zero readback, then 64-bit BAR in the final slot
    send_bar(32'h1234_5678, 32'h0000_0000, 1'b1);
    send_bar(32'hFFFF_FFF4, 32'hFFFF_FFF4, 1'b1);
    // Field extremes and the other memory types
    send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
    send_bar(32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
    send_bar(32'h000F_0002, 32'hFFFF_0002, 1'b0);
    send_bar(32'h1000_0006, 32'hFFFF_FFF6, 1'b0);
    // Header turns bridge with the counter past its count: slot becomes final
    send_bar(32'h0000_0001, 32'h0000_0001, 1'b1);
    // Header change while a 64-bit BAR is held
    send_bar(32'h0000_E001, 32'hFFFF_FF01, 1'b0);
    send_bar(32'h0000_0004, 32'hFFFF_FFF4, 1'b0);
    send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // Held as a bridge low half, upper half arrives under a normal header
    send_bar(32'h4000_000C, 32'hC000_000C, 1'b1);
    send_bar(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);

    while (in_count < 20 + RANDOM_ITEMS) begin
      send_device();
      dev_count++;
    end
    in_valid <= 1'b0;

    // A low half may still be held; it owes no descriptor yet.
    while (sb.desc_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.desc_q.size() != 0) begin
      $error("%0d descriptors never arrived", sb.desc_q.size());
      sb.errors++;
    end

    $display("Run sent %0d slot items (%0d random devices) and checked %0d descriptors:",
             in_count, dev_count, sb.checked);
    $display("  none %0d, I/O %0d, mem32 %0d, mem64 %0d",
             sb.kind_seen[KIND_NONE], sb.kind_seen[KIND_IO],
             sb.kind_seen[KIND_MEM32], sb.kind_seen[KIND_MEM64]);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
